/* rtl/spc_pkg.sv */
// Package: equal-loudness contour tables, widths and status codes for the SPL to phon converter.
package spc_pkg;

  localparam int NUM_FREQS    = 31;
  localparam int NUM_CONTOURS = 7;
  localparam int QBITS        = 13;  // quotient bits, max phon step * 256 < 2**13

  localparam logic [18:0] BAND_LOW_Q4  = 19'd320;
  localparam logic [18:0] BAND_HIGH_Q4 = 19'd320000;
  localparam logic [14:0] TOP_PHON_Q8  = 15'd25600;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAND = 2'd1;
  localparam logic [1:0] ST_LOW  = 2'd2;
  localparam logic [1:0] ST_TOP  = 2'd3;

  typedef logic signed [14:0] lvl_t;

  localparam logic [18:0] FREQ_ROM [NUM_FREQS] = '{
    19'd320, 19'd400, 19'd504, 19'd640, 19'd800, 19'd1008, 19'd1280, 19'd1600,
    19'd2000, 19'd2560, 19'd3200, 19'd4000, 19'd5040, 19'd6400, 19'd8000,
    19'd10080, 19'd12800, 19'd16000, 19'd20000, 19'd25600, 19'd32000, 19'd40000,
    19'd50400, 19'd64000, 19'd80000, 19'd100800, 19'd128000, 19'd160000,
    19'd200000, 19'd256000, 19'd320000
  };

  localparam logic [6:0] PHON_ROM [NUM_CONTOURS] = '{
    7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd100
  };

  // contour levels in 1/100 dB
  localparam lvl_t LEVEL_ROM [NUM_CONTOURS][NUM_FREQS] = '{
    '{ 15'sd7655, 15'sd6562, 15'sd5512, 15'sd4553, 15'sd3763, 15'sd3086, 15'sd2502,
       15'sd2051, 15'sd1665, 15'sd1312, 15'sd1009, 15'sd754, 15'sd511, 15'sd306,
       15'sd148, 15'sd30, -15'sd30, -15'sd1, 15'sd103, -15'sd119, -15'sd411,
       -15'sd705, -15'sd903, -15'sd849, -15'sd448, 15'sd328, 15'sd983, 15'sd1048,
       15'sd838, 15'sd1410, 15'sd7965 },
    '{ 15'sd8375, 15'sd7576, 15'sd6821, 15'sd6114, 15'sd5496, 15'sd4901, 15'sd4324,
       15'sd3813, 15'sd3348, 15'sd2877, 15'sd2484, 15'sd2133, 15'sd1805, 15'sd1514,
       15'sd1298, 15'sd1118, 15'sd999, 15'sd1000, 15'sd1126, 15'sd1043, 15'sd727,
       15'sd445, 15'sd304, 15'sd380, 15'sd746, 15'sd1435, 15'sd2098, 15'sd2343,
       15'sd2233, 15'sd2517, 15'sd8147 },
    '{ 15'sd8958, 15'sd8265, 15'sd7598, 15'sd6962, 15'sd6402, 15'sd5855, 15'sd5319,
       15'sd4838, 15'sd4394, 15'sd3937, 15'sd3551, 15'sd3199, 15'sd2869, 15'sd2567,
       15'sd2343, 15'sd2148, 15'sd2010, 15'sd2001, 15'sd2146, 15'sd2140, 15'sd1815,
       15'sd1538, 15'sd1426, 15'sd1514, 15'sd1863, 15'sd2502, 15'sd3152, 15'sd3443,
       15'sd3304, 15'sd3467, 15'sd8418 },
    '{ 15'sd9985, 15'sd9394, 15'sd8817, 15'sd8263, 15'sd7778, 15'sd7308, 15'sd6848,
       15'sd6437, 15'sd6059, 15'sd5670, 15'sd5341, 15'sd5040, 15'sd4758, 15'sd4498,
       15'sd4305, 15'sd4134, 15'sd4006, 15'sd4001, 15'sd4182, 15'sd4251, 15'sd3923,
       15'sd3651, 15'sd3561, 15'sd3665, 15'sd4001, 15'sd4583, 15'sd5180, 15'sd5428,
       15'sd5149, 15'sd5196, 15'sd9277 },
    '{ 15'sd10951, 15'sd10423, 15'sd9908, 15'sd9418, 15'sd8996, 15'sd8594, 15'sd8205,
       15'sd7865, 15'sd7556, 15'sd7247, 15'sd6986, 15'sd6753, 15'sd6539, 15'sd6345,
       15'sd6205, 15'sd6081, 15'sd5989, 15'sd6001, 15'sd6215, 15'sd6319, 15'sd5996,
       15'sd5726, 15'sd5642, 15'sd5757, 15'sd6089, 15'sd6636, 15'sd7166, 15'sd7316,
       15'sd6863, 15'sd6843, 15'sd10492 },
    '{ 15'sd11899, 15'sd11423, 15'sd10965, 15'sd10534, 15'sd10172, 15'sd9836,
       15'sd9517, 15'sd9248, 15'sd9009, 15'sd8782, 15'sd8592, 15'sd8431, 15'sd8289,
       15'sd8168, 15'sd8086, 15'sd8017, 15'sd7967, 15'sd8001, 15'sd8248, 15'sd8374,
       15'sd8059, 15'sd7788, 15'sd7707, 15'sd7831, 15'sd8162, 15'sd8681, 15'sd9141,
       15'sd9174, 15'sd8541, 15'sd8467, 15'sd11895 },
    '{ 15'sd12841, 15'sd12415, 15'sd12011, 15'sd11638, 15'sd11335, 15'sd11065,
       15'sd10816, 15'sd10617, 15'sd10448, 15'sd10303, 15'sd10185, 15'sd10097,
       15'sd10030, 15'sd9983, 15'sd9962, 15'sd9950, 15'sd9944, 15'sd10001, 15'sd10281,
       15'sd10425, 15'sd10118, 15'sd9848, 15'sd9767, 15'sd9900, 15'sd10230,
       15'sd10723, 15'sd11111, 15'sd11023, 15'sd10207, 15'sd10083, 15'sd13373 }
  };

endpackage

/* rtl/spl_to_phon_converter_core.sv */
// Top level: pipelined SPL to phon converter (contour interpolation and divider pipeline).
// A word accepted with start high passes through every register stage and leaves with out_valid high.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// 21 register stages: 7 interpolation stages (the first loads at the accepting edge),
// 13 restoring-divide stages (one quotient bit each) and the output register.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module spl_to_phon_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [18:0] in_frequency_q4,
  input  logic signed [16:0] in_level_q8,
  output logic        out_valid,
  output logic [14:0] out_loudness_q8,
  output logic [1:0]  out_status
);

  localparam int NC = spc_pkg::NUM_CONTOURS;
  localparam int QB = spc_pkg::QBITS;

  assign busy = 1'b0;

  // valid bits for the interpolation stages 1..7 and divider stages 1..QB
  logic [7:1]  vld_r;
  logic [QB:1] dvld_r;

  // ---- stage 1: register input, band check, level * 100, frequency bin search
  logic [18:0]        s1_f_r;
  logic signed [23:0] s1_lvl100_r;
  logic               s1_band_r;
  logic [4:0]         s1_k_r;
  logic [4:0]         k_nxt;

  // k = first table index above f, clamped to the last bin
  always_comb begin
    k_nxt = 5'd1;
    for (int j = 1; j < spc_pkg::NUM_FREQS - 1; j++) begin
      if (in_frequency_q4 >= spc_pkg::FREQ_ROM[j]) k_nxt = k_nxt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    s1_f_r      <= in_frequency_q4;
    s1_lvl100_r <= 24'(in_level_q8) * 24'sd100;
    s1_band_r   <= (in_frequency_q4 > spc_pkg::BAND_LOW_Q4) &&
                   (in_frequency_q4 < spc_pkg::BAND_HIGH_Q4);
    s1_k_r      <= k_nxt;
  end

  // ---- stage 2: step size, offset and contour end points from the tables
  logic [16:0]        s2_d_r, s2_df_r;
  logic signed [23:0] s2_lvl100_r;
  logic               s2_band_r;
  spc_pkg::lvl_t      s2_y1_r [NC];
  logic signed [15:0] s2_dy_r [NC];

  always_ff @(posedge clk) begin
    s2_d_r      <= 17'(spc_pkg::FREQ_ROM[s1_k_r] - spc_pkg::FREQ_ROM[s1_k_r - 5'd1]);
    s2_df_r     <= 17'(s1_f_r - spc_pkg::FREQ_ROM[s1_k_r - 5'd1]);
    s2_lvl100_r <= s1_lvl100_r;
    s2_band_r   <= s1_band_r;
    for (int c = 0; c < NC; c++) begin
      s2_y1_r[c] <= spc_pkg::LEVEL_ROM[c][s1_k_r - 5'd1];
      s2_dy_r[c] <= 16'(16'(spc_pkg::LEVEL_ROM[c][s1_k_r])
                        - 16'(spc_pkg::LEVEL_ROM[c][s1_k_r - 5'd1]));
    end
  end

  // ---- stage 3: products; level scaled by step, contour terms
  logic signed [40:0] s3_a_r;
  logic               s3_band_r;
  logic signed [32:0] s3_m1_r [NC];
  logic signed [32:0] s3_m2_r [NC];

  always_ff @(posedge clk) begin
    s3_a_r    <= 41'(s2_lvl100_r) * 41'($signed({1'b0, s2_d_r}));
    s3_band_r <= s2_band_r;
    for (int c = 0; c < NC; c++) begin
      s3_m1_r[c] <= 33'(s2_y1_r[c]) * 33'($signed({1'b0, s2_d_r}));
      s3_m2_r[c] <= 33'(s2_dy_r[c]) * 33'($signed({1'b0, s2_df_r}));
    end
  end

  // ---- stage 4: contour values at the input frequency (scaled by step)
  logic signed [40:0] s4_a_r;
  logic               s4_band_r;
  logic signed [32:0] s4_w_r [NC];

  always_ff @(posedge clk) begin
    s4_a_r    <= s3_a_r;
    s4_band_r <= s3_band_r;
    for (int c = 0; c < NC; c++) s4_w_r[c] <= s3_m1_r[c] + s3_m2_r[c];
  end

  // ---- stage 5: compare the level against every contour
  logic signed [40:0] s5_a_r;
  logic               s5_band_r;
  logic signed [32:0] s5_w_r [NC];
  logic [NC-1:0]      s5_ge_r;

  always_ff @(posedge clk) begin
    s5_a_r    <= s4_a_r;
    s5_band_r <= s4_band_r;
    for (int c = 0; c < NC; c++) begin
      s5_w_r[c]  <= s4_w_r[c];
      s5_ge_r[c] <= s4_a_r >= $signed({s4_w_r[c], 8'd0});
    end
  end

  // ---- stage 6: pick bracketing contours, numerator and denominator
  logic [2:0]         hi_c;
  logic [2:0]         lo_c;
  logic [1:0]         st_nxt;
  logic signed [40:0] num_nxt;
  logic signed [32:0] den_nxt;

  // contours increase, so the compare vector is a thermometer
  always_comb begin
    hi_c = 3'd1;
    for (int c = 1; c < NC; c++) begin
      if (s5_ge_r[c]) hi_c = hi_c + 3'd1;
    end
    if (hi_c == 3'(NC)) lo_c = 3'(NC - 1);
    else                lo_c = hi_c - 3'd1;
    if (!s5_band_r)               st_nxt = spc_pkg::ST_BAND;
    else if (!s5_ge_r[0])         st_nxt = spc_pkg::ST_LOW;
    else if (hi_c == 3'(NC))      st_nxt = spc_pkg::ST_TOP;
    else                          st_nxt = spc_pkg::ST_OK;
    num_nxt = s5_a_r - {s5_w_r[lo_c], 8'd0};
    den_nxt = s5_w_r[lo_c + 3'd1 > 3'(NC - 1) ? lo_c : lo_c + 3'd1] - s5_w_r[lo_c];
  end

  logic [39:0] s6_num_r;
  logic [31:0] s6_den_r;
  logic [4:0]  s6_dph_r;
  logic [14:0] s6_p0_r;
  logic [1:0]  s6_st_r;

  always_ff @(posedge clk) begin
    s6_num_r <= num_nxt[39:0];
    s6_den_r <= den_nxt[31:0];
    s6_dph_r <= 5'(spc_pkg::PHON_ROM[lo_c + 3'd1 > 3'(NC - 1) ? lo_c : lo_c + 3'd1]
                   - spc_pkg::PHON_ROM[lo_c]);
    s6_p0_r  <= {spc_pkg::PHON_ROM[lo_c], 8'd0};
    s6_st_r  <= st_nxt;
  end

  // divider pipeline registers; index 0 is stage 7
  logic [44:0]   dv_rem_r [QB+1];
  logic [31:0]   dv_den_r [QB+1];
  logic [QB-1:0] dv_q_r   [QB+1];
  logic [14:0]   dv_p0_r  [QB+1];
  logic [1:0]    dv_st_r  [QB+1];

  // ---- stage 7: numerator times phon step; quotient then fits in QB bits
  always_ff @(posedge clk) begin
    dv_rem_r[0] <= 45'(s6_num_r) * 45'(s6_dph_r);
    dv_den_r[0] <= s6_den_r;
    dv_q_r[0]   <= '0;
    dv_p0_r[0]  <= s6_p0_r;
    dv_st_r[0]  <= s6_st_r;
  end

  // ---- divider: restoring, one quotient bit per stage, MSB first
  for (genvar i = 1; i <= QB; i++) begin : g_div
    logic [44:0] sub;
    assign sub = 45'({dv_den_r[i-1], {(QB - i){1'b0}}});
    always_ff @(posedge clk) begin
      dv_den_r[i] <= dv_den_r[i-1];
      dv_p0_r[i]  <= dv_p0_r[i-1];
      dv_st_r[i]  <= dv_st_r[i-1];
      if (dv_rem_r[i-1] >= sub) begin
        dv_rem_r[i]        <= dv_rem_r[i-1] - sub;
        dv_q_r[i]          <= dv_q_r[i-1] | (QB'(1) << (QB - i));
      end else begin
        dv_rem_r[i]        <= dv_rem_r[i-1];
        dv_q_r[i]          <= dv_q_r[i-1];
      end
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    case (dv_st_r[QB])
      spc_pkg::ST_OK:  out_loudness_q8 <= dv_p0_r[QB] + 15'(dv_q_r[QB]);
      spc_pkg::ST_TOP: out_loudness_q8 <= spc_pkg::TOP_PHON_Q8;
      default:         out_loudness_q8 <= '0;
    endcase
    out_status <= dv_st_r[QB];
  end

  // ---- valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      dvld_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[6:1], start && !busy};
      dvld_r    <= {dvld_r[QB-1:1], vld_r[7]};
      out_valid <= dvld_r[QB];
    end
  end

endmodule
